// ===== hw/rtl/ffba_pkg.sv =====
// Shared constants and types for the first-fit block allocator.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.

package ffba_pkg;

  // Default parameter values for the top level.
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int IDX_BITS = 4;
  localparam int PID_BITS = 8;
  localparam int CFG_BITS = 5;

  // Request action codes. The unused code is handled as a read.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  // Strobes from the controller to the block table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== hw/rtl/ffba_if.sv =====
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on ffba_pkg for field widths and defaults.

interface ffba_req_if #(
  parameter int SIZE_BITS = ffba_pkg::SIZE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [ffba_pkg::IDX_BITS-1:0] block_index;
  logic [SIZE_BITS-1:0]          size_kb;
  logic [ffba_pkg::PID_BITS-1:0] process_id;

  modport source (output valid, output action, output block_index, output size_kb,
                  output process_id, input ready);
  modport sink   (input valid, input action, input block_index, input size_kb,
                  input process_id, output ready);
endinterface

interface ffba_rsp_if #(
  parameter int SIZE_BITS = ffba_pkg::SIZE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [ffba_pkg::IDX_BITS-1:0] chosen_block;
  logic [SIZE_BITS-1:0]          remaining_kb;
  logic [SIZE_BITS-1:0]          original_kb;
  logic [ffba_pkg::PID_BITS-1:0] owner;

  modport source (output valid, output status, output chosen_block, output remaining_kb,
                  output original_kb, output owner, input ready);
  modport sink   (input valid, input status, input chosen_block, input remaining_kb,
                  input original_kb, input owner, output ready);
endinterface

// ===== hw/rtl/ffba_table.sv =====
// Block table: one synchronous memory holding remaining size, original size and owner.
// Depends on ffba_pkg for the control struct and the owner width.

module ffba_table #(
  parameter int DEPTH     = ffba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS = ffba_pkg::SIZE_BITS_DEF,
  parameter int AW        = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ffba_pkg::mem_ctl_t            ctl,
  input  logic [AW-1:0]                 rd_addr,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [SIZE_BITS-1:0]          wr_rem,
  input  logic [SIZE_BITS-1:0]          wr_orig,
  input  logic [ffba_pkg::PID_BITS-1:0] wr_owner,
  output logic [SIZE_BITS-1:0]          rd_rem,
  output logic [SIZE_BITS-1:0]          rd_orig,
  output logic [ffba_pkg::PID_BITS-1:0] rd_owner
);

  localparam int EW = 2 * SIZE_BITS + ffba_pkg::PID_BITS;

  logic [EW-1:0]    mem [DEPTH];
  logic [EW-1:0]    rd_q;
  logic             rd_vld_q;
  // An entry never written reads as free.
  logic [DEPTH-1:0] written;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {wr_rem, wr_orig, wr_owner};
    end
    if (ctl.rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ctl.wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  assign rd_rem   = rd_q[EW-1 -: SIZE_BITS];
  assign rd_orig  = rd_q[ffba_pkg::PID_BITS +: SIZE_BITS];
  assign rd_owner = rd_vld_q ? rd_q[ffba_pkg::PID_BITS-1:0] : '0;

endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
// Top level of the first-fit fixed-partition block allocator.
// Depends on ffba_pkg, the channel interfaces in ffba_if.sv and the block table ffba_table.
//
//   Channel   Dir   Handshake          Contents
//   req       in    valid/ready        action, block_index, size_kb, process_id
//   rsp       out   valid/ready        status, chosen_block, remaining_kb, original_kb, owner
//   cfg       in    cfg_we only        cfg_data = blocks in use
//
// A load, or a request whose index is beyond the blocks in use, is staged at acceptance
// and moves to the output register from ST_EMIT; a read first passes ST_FETCH for the
// table read; an allocation scans in ST_SCAN, one block per cycle, up to the blocks in use.
// The next request is taken back in ST_IDLE. Reset is synchronous and active high; it
// clears the controller, the output valid and the per-block written flags, so every block
// starts free. A finished response waits while the output register is full, stalling input.

module first_fit_block_allocator #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ffba_pkg::CFG_BITS-1:0] cfg_data,
  ffba_req_if.sink                      req,
  ffba_rsp_if.source                    rsp
);

  // Table address width, and a count width that can hold NUM_BLOCKS itself.
  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int PW = ffba_pkg::PID_BITS;
  localparam int IW = ffba_pkg::IDX_BITS;

  // Configuration register.
  logic [ffba_pkg::CFG_BITS-1:0] blocks_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= '0;
    end else if (cfg_we) begin
      blocks_in_use <= cfg_data;
    end
  end

  // Active block count, saturated to the table depth.
  logic [CW-1:0] count_c;
  logic          in_range;

  assign count_c  = (9'(blocks_in_use) > 9'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                         : CW'(blocks_in_use);
  assign in_range = 9'(req.block_index) < 9'(count_c);

  // Controller state and the fields of the request being worked on.
  ffba_pkg::state_t state, state_next;
  logic [SIZE_BITS-1:0] size_q;
  logic [PW-1:0]        pid_q;
  logic [IW-1:0]        idx_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        scan_idx;
  logic [CW-1:0]        next_idx;

  // Table port signals.
  ffba_pkg::mem_ctl_t   ctl;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [SIZE_BITS-1:0] wr_rem, wr_orig, rd_rem, rd_orig;
  logic [PW-1:0]        wr_owner, rd_owner;
  logic                 fit;

  // Staged response, held until the output register has room.
  logic                 stage_ld;
  ffba_pkg::status_t    st_status, st_status_next;
  logic [IW-1:0]        st_blk, st_blk_next;
  logic [SIZE_BITS-1:0] st_rem, st_rem_next, st_orig, st_orig_next;
  logic [PW-1:0]        st_own, st_own_next;
  logic                 scan_ld;
  logic [CW-1:0]        scan_idx_next;

  // Output register.
  logic                 out_valid;
  logic                 out_free;
  ffba_pkg::status_t    out_status;
  logic [IW-1:0]        out_blk;
  logic [SIZE_BITS-1:0] out_rem, out_orig;
  logic [PW-1:0]        out_own;

  ffba_table #(
    .DEPTH     (NUM_BLOCKS),
    .SIZE_BITS (SIZE_BITS),
    .AW        (AW)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_rem   (wr_rem),
    .wr_orig  (wr_orig),
    .wr_owner (wr_owner),
    .rd_rem   (rd_rem),
    .rd_orig  (rd_orig),
    .rd_owner (rd_owner)
  );

  assign next_idx = scan_idx + 1'b1;
  // During a scan the table output holds the block at scan_idx. A block is taken when it
  // is free and still has at least the requested space.
  assign fit      = (rd_owner == '0) && (rd_rem >= size_q);
  assign out_free = !out_valid || rsp.ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ffba_pkg::ST_IDLE: begin
        if (req.valid) begin
          case (req.action)
            ffba_pkg::ACT_ALLOC: begin
              state_next = (count_c == '0) ? ffba_pkg::ST_EMIT : ffba_pkg::ST_SCAN;
            end
            ffba_pkg::ACT_LOAD: begin
              state_next = ffba_pkg::ST_EMIT;
            end
            default: begin
              state_next = in_range ? ffba_pkg::ST_FETCH : ffba_pkg::ST_EMIT;
            end
          endcase
        end
      end
      ffba_pkg::ST_SCAN: begin
        if (fit || (next_idx == count_q)) begin
          state_next = ffba_pkg::ST_EMIT;
        end
      end
      ffba_pkg::ST_FETCH: begin
        state_next = ffba_pkg::ST_EMIT;
      end
      ffba_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = ffba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffba_pkg::ST_IDLE;
      end
    endcase
  end

  // Output logic: table accesses, response staging and scan pointer updates.
  always_comb begin
    req.ready      = 1'b0;
    ctl            = '0;
    rd_addr        = AW'(req.block_index);
    wr_addr        = AW'(req.block_index);
    wr_rem         = req.size_kb;
    wr_orig        = req.size_kb;
    wr_owner       = '0;
    stage_ld       = 1'b0;
    st_status_next = ffba_pkg::STAT_OK;
    st_blk_next    = req.block_index;
    st_rem_next    = '0;
    st_orig_next   = '0;
    st_own_next    = '0;
    scan_ld        = 1'b0;
    scan_idx_next  = '0;
    case (state)
      ffba_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          case (req.action)
            ffba_pkg::ACT_ALLOC: begin
              if (count_c == '0) begin
                stage_ld       = 1'b1;
                st_status_next = ffba_pkg::STAT_NOFIT;
                st_blk_next    = '0;
              end else begin
                ctl.rd_en = 1'b1;
                rd_addr   = '0;
                scan_ld   = 1'b1;
              end
            end
            ffba_pkg::ACT_LOAD: begin
              stage_ld = 1'b1;
              if (in_range) begin
                // A load sets both sizes and frees the block.
                ctl.wr_en    = 1'b1;
                st_rem_next  = req.size_kb;
                st_orig_next = req.size_kb;
              end else begin
                st_status_next = ffba_pkg::STAT_RANGE;
              end
            end
            default: begin
              if (in_range) begin
                ctl.rd_en = 1'b1;
              end else begin
                stage_ld       = 1'b1;
                st_status_next = ffba_pkg::STAT_RANGE;
              end
            end
          endcase
        end
      end
      ffba_pkg::ST_SCAN: begin
        if (fit) begin
          // Grant: the leftover stays with the block and is reused only if the owner is zero.
          ctl.wr_en    = 1'b1;
          wr_addr      = scan_idx[AW-1:0];
          wr_rem       = rd_rem - size_q;
          wr_orig      = rd_orig;
          wr_owner     = pid_q;
          stage_ld     = 1'b1;
          st_blk_next  = IW'(scan_idx);
          st_rem_next  = rd_rem - size_q;
          st_orig_next = rd_orig;
          st_own_next  = pid_q;
        end else if (next_idx == count_q) begin
          stage_ld       = 1'b1;
          st_status_next = ffba_pkg::STAT_NOFIT;
          st_blk_next    = '0;
        end else begin
          ctl.rd_en     = 1'b1;
          rd_addr       = next_idx[AW-1:0];
          scan_ld       = 1'b1;
          scan_idx_next = next_idx;
        end
      end
      ffba_pkg::ST_FETCH: begin
        stage_ld     = 1'b1;
        st_blk_next  = idx_q;
        st_rem_next  = rd_rem;
        st_orig_next = rd_orig;
        st_own_next  = rd_owner;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request fields are captured at acceptance; these payload registers need no reset.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      size_q  <= req.size_kb;
      pid_q   <= req.process_id;
      idx_q   <= req.block_index;
      count_q <= count_c;
    end
    if (scan_ld) begin
      scan_idx <= scan_idx_next;
    end
    if (stage_ld) begin
      st_status <= st_status_next;
      st_blk    <= st_blk_next;
      st_rem    <= st_rem_next;
      st_orig   <= st_orig_next;
      st_own    <= st_own_next;
    end
  end

  // The output register is loaded from the staged response when it is empty or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ffba_pkg::ST_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ffba_pkg::ST_EMIT) && out_free) begin
      out_status <= st_status;
      out_blk    <= st_blk;
      out_rem    <= st_rem;
      out_orig   <= st_orig;
      out_own    <= st_own;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.chosen_block = out_blk;
  assign rsp.remaining_kb = out_rem;
  assign rsp.original_kb  = out_orig;
  assign rsp.owner        = out_own;

endmodule

// ===== sim/first_fit_block_allocator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_block_allocator: directed and random traffic with a
// built-in predictor of the block table. Depends on ffba_pkg, ffba_if.sv and the RTL.

module first_fit_block_allocator_tb;

  localparam int BLOCKS    = ffba_pkg::NUM_BLOCKS_DEF;
  localparam int SIZE_W    = ffba_pkg::SIZE_BITS_DEF;
  localparam int IDX_W     = ffba_pkg::IDX_BITS;
  localparam int PID_W     = ffba_pkg::PID_BITS;
  localparam int CFG_W     = ffba_pkg::CFG_BITS;
  localparam int MAX_CYCLE = 400000;
  localparam int HOLD_LEN  = 300;
  localparam int SETTLE    = BLOCKS + 8;

  // One request as it travels on the request channel.
  typedef struct packed {
    logic [1:0]       act;
    logic [IDX_W-1:0] idx;
    logic [SIZE_W-1:0] size;
    logic [PID_W-1:0] pid;
  } alloc_req_t;

  // One response as it is expected on the response channel.
  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  blk;
    logic [SIZE_W-1:0] rem;
    logic [SIZE_W-1:0] orig;
    logic [PID_W-1:0]  own;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Everything the testbench drives into the channels comes from these variables, so each
  // input holds a known value from time zero.
  logic       drv_valid = 1'b0;
  alloc_req_t drv_req   = '0;
  logic       rsp_rdy   = 1'b0;

  ffba_req_if #(.SIZE_BITS(SIZE_W)) req_if ();
  ffba_rsp_if #(.SIZE_BITS(SIZE_W)) rsp_if ();

  assign req_if.valid       = drv_valid;
  assign req_if.action      = drv_req.act;
  assign req_if.block_index = drv_req.idx;
  assign req_if.size_kb     = drv_req.size;
  assign req_if.process_id  = drv_req.pid;
  assign rsp_if.ready       = rsp_rdy;

  first_fit_block_allocator #(
    .NUM_BLOCKS(BLOCKS),
    .SIZE_BITS (SIZE_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .req     (req_if),
    .rsp     (rsp_if)
  );

  always #1 clk = ~clk;

  // Requests waiting to be offered, and the responses owed for requests already taken.
  alloc_req_t queued_requests[$];
  alloc_rsp_t owed_replies[$];

  // Predicted contents of the block table and the active block count (already saturated).
  logic [SIZE_W-1:0] blk_left [BLOCKS];
  logic [SIZE_W-1:0] blk_size [BLOCKS];
  logic [PID_W-1:0]  blk_owner[BLOCKS];
  int                live_blocks = 0;

  // The stimulus side keeps its own view of which blocks hold a size. A block that was
  // never loaded must never be read or scanned, since its contents are undefined.
  bit loaded[BLOCKS];
  int gen_live = 0;

  // Traffic shaping, set by the stimulus sequence. "calm" turns off random idling on both
  // sides; "hold_req" asks the response side for one long stall.
  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt  = 0;

  bit req_took = 1'b0;
  int fail_count = 0;
  int cycle_count = 0;

  initial begin
    for (int i = 0; i < BLOCKS; i++) begin
      blk_left[i]  = '0;
      blk_size[i]  = '0;
      blk_owner[i] = '0;
      loaded[i]    = 1'b0;
    end
  end

  // Work out the response to one request and update the predicted table. An allocation
  // takes the first free block, in index order, whose remaining size covers the request.
  // The request is carved out of that block and the rest of it is lost. Owner zero means
  // free, so an allocation for process zero shrinks the block but leaves it free.
  function automatic alloc_rsp_t serve_request(input alloc_req_t r);
    alloc_rsp_t o;
    int         j;
    bit         found;
    o = '0;
    found = 1'b0;
    if (r.act == ffba_pkg::ACT_ALLOC) begin
      o.status = ffba_pkg::STAT_NOFIT;
      for (j = 0; j < live_blocks && !found; j++) begin
        if (blk_owner[j] == '0 && blk_left[j] >= r.size) begin
          found        = 1'b1;
          blk_left[j]  = blk_left[j] - r.size;
          blk_owner[j] = r.pid;
          o.status     = ffba_pkg::STAT_OK;
          o.blk        = j[IDX_W-1:0];
          o.rem        = blk_left[j];
          o.orig       = blk_size[j];
          o.own        = blk_owner[j];
        end
      end
    end else if (int'(r.idx) >= live_blocks) begin
      // Index outside the active blocks: a load is dropped, a read reports nothing.
      o.status = ffba_pkg::STAT_RANGE;
      o.blk    = r.idx;
    end else begin
      // A load sets both sizes and frees the block. The unused action code reads.
      if (r.act == ffba_pkg::ACT_LOAD) begin
        blk_left[r.idx]  = r.size;
        blk_size[r.idx]  = r.size;
        blk_owner[r.idx] = '0;
      end
      o.status = ffba_pkg::STAT_OK;
      o.blk    = r.idx;
      o.rem    = blk_left[r.idx];
      o.orig   = blk_size[r.idx];
      o.own    = blk_owner[r.idx];
    end
    return o;
  endfunction

  // Request driver. A new request goes out at the falling edge once the previous one was
  // taken; a slot is left empty about 14 times in 100 unless traffic is calm.
  always @(negedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || req_took) begin
      if (queued_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
        drv_req   <= queued_requests.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Response receiver. It stalls at random, and once on request it holds off for a long
  // stretch so that the allocator backs up and stops taking requests.
  always @(negedge clk) begin
    if (rst) begin
      rsp_rdy <= 1'b0;
    end else if (hold_cnt != 0) begin
      rsp_rdy  <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      rsp_rdy   <= 1'b0;
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      rsp_rdy <= calm || ($urandom_range(0, 99) >= 14);
    end
  end

  // Monitor. Both channels are sampled at the rising edge. A response is checked against
  // the oldest owed one before the request taken at the same edge is predicted.
  always @(posedge clk) begin
    alloc_rsp_t got;
    alloc_rsp_t want;
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("first_fit_block_allocator_tb: done, errors");
      $finish;
    end else begin
      req_took <= req_if.valid && req_if.ready;
      if (!rst) begin
        if (rsp_if.valid && rsp_if.ready) begin
          got = '{rsp_if.status, rsp_if.chosen_block, rsp_if.remaining_kb,
                  rsp_if.original_kb, rsp_if.owner};
          if (owed_replies.size() == 0) begin
            if (fail_count < 10)
              $display("%0t: response with none expected:", $realtime,
                       " st=%0d blk=%0d rem=%0d orig=%0d own=%0d",
                       got.status, got.blk, got.rem, got.orig, got.own);
            fail_count++;
          end else begin
            want = owed_replies.pop_front();
            if (got.status !== want.status || got.blk !== want.blk || got.rem !== want.rem ||
                got.orig !== want.orig || got.own !== want.own) begin
              if (fail_count < 10)
                $display("%0t: mismatch exp st=%0d blk=%0d rem=%0d orig=%0d own=%0d,",
                         $realtime, want.status, want.blk, want.rem, want.orig, want.own,
                         " got st=%0d blk=%0d rem=%0d orig=%0d own=%0d",
                         got.status, got.blk, got.rem, got.orig, got.own);
              fail_count++;
            end
          end
        end
        if (req_if.valid && req_if.ready)
          owed_replies.push_back(serve_request('{req_if.action, req_if.block_index,
                                                 req_if.size_kb, req_if.process_id}));
      end
    end
  end

  // Queue one request and keep track of which blocks have been given a size.
  task automatic push_req(input logic [1:0] act, input int idx, input int size,
                          input int pid);
    alloc_req_t r;
    r.act  = act;
    r.idx  = idx[IDX_W-1:0];
    r.size = size[SIZE_W-1:0];
    r.pid  = pid[PID_W-1:0];
    if (act == ffba_pkg::ACT_LOAD && idx < gen_live)
      loaded[idx] = 1'b1;
    queued_requests.push_back(r);
  endtask

  // Wait until the allocator has nothing left to do for us.
  task automatic drain();
    while (queued_requests.size() != 0 || drv_valid || owed_replies.size() != 0)
      @(negedge clk);
  endtask

  // Change the number of active blocks. Only done with the allocator idle; the extra wait
  // covers a full allocation scan in case anything is still in flight.
  task automatic set_blocks_in_use(input int n);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_data = n[CFG_W-1:0];
    cfg_we   = 1'b1;
    live_blocks = (n > BLOCKS) ? BLOCKS : n;
    gen_live    = live_blocks;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random traffic. Most allocations ask for modest sizes so that many of them fit, and
  // loads keep freeing blocks for reuse. Any request that would touch a block never loaded
  // is turned into a load of that block instead.
  task automatic queue_random(input int n);
    int         pick;
    int         hole;
    int         k;
    logic [1:0] act;
    int         idx;
    int         size;
    int         pid;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      act = ffba_pkg::ACT_LOAD;
      else if (pick < 70) act = ffba_pkg::ACT_ALLOC;
      else if (pick < 94) act = ffba_pkg::ACT_READ;
      else                act = ffba_pkg::ACT_SPARE;
      if (gen_live == 0 || $urandom_range(0, 7) == 0)
        idx = $urandom_range(0, BLOCKS - 1);
      else
        idx = $urandom_range(0, gen_live - 1);
      case ($urandom_range(0, 3))
        0:       size = $urandom_range(0, 65535);
        1:       size = $urandom_range(0, 255);
        default: size = $urandom_range(0, 4095);
      endcase
      pid = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255);
      hole = -1;
      for (k = gen_live - 1; k >= 0; k--)
        if (!loaded[k]) hole = k;
      if (act == ffba_pkg::ACT_ALLOC && hole >= 0) begin
        act = ffba_pkg::ACT_LOAD;
        idx = hole;
      end else if (act != ffba_pkg::ACT_LOAD && act != ffba_pkg::ACT_ALLOC &&
                   idx < gen_live && !loaded[idx]) begin
        act = ffba_pkg::ACT_LOAD;
      end
      push_req(act, idx, size, pid);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part with four active blocks: size extremes, out-of-range load and read,
    // the unused action code, a zero-size request, process zero, an exact fit, no fit,
    // and a reload that frees an owned block.
    set_blocks_in_use(4);
    push_req(ffba_pkg::ACT_LOAD,  0, 16'hFFFF, 0);
    push_req(ffba_pkg::ACT_LOAD,  1, 0,        0);
    push_req(ffba_pkg::ACT_LOAD,  2, 100,      0);
    push_req(ffba_pkg::ACT_LOAD,  3, 16'h8000, 0);
    push_req(ffba_pkg::ACT_LOAD,  9, 1234,     0);
    push_req(ffba_pkg::ACT_READ,  15, 0,       0);
    push_req(ffba_pkg::ACT_SPARE, 3, 0,        0);
    push_req(ffba_pkg::ACT_ALLOC, 0, 16'hFFFF, 255);
    push_req(ffba_pkg::ACT_ALLOC, 0, 0,        0);
    push_req(ffba_pkg::ACT_ALLOC, 0, 0,        1);
    push_req(ffba_pkg::ACT_ALLOC, 0, 16'h9000, 2);
    push_req(ffba_pkg::ACT_ALLOC, 0, 100,      3);
    push_req(ffba_pkg::ACT_READ,  0, 0,        0);
    push_req(ffba_pkg::ACT_READ,  1, 0,        0);
    push_req(ffba_pkg::ACT_READ,  2, 0,        0);
    push_req(ffba_pkg::ACT_ALLOC, 0, 1,        4);
    push_req(ffba_pkg::ACT_LOAD,  0, 5,        0);
    push_req(ffba_pkg::ACT_ALLOC, 15, 5,       128);
    push_req(ffba_pkg::ACT_READ,  0, 0,        0);

    // Random phases across several table sizes, the extremes among them. One phase runs
    // with no idling at all; another has the receiver stall long enough to back up.
    set_blocks_in_use(16);
    queue_random(95);
    set_blocks_in_use(0);
    queue_random(95);
    set_blocks_in_use(31);
    queue_random(95);
    set_blocks_in_use(1);
    queue_random(95);
    set_blocks_in_use(9);
    calm <= 1'b1;
    queue_random(95);
    set_blocks_in_use(16);
    calm <= 1'b0;
    queue_random(95);
    hold_req <= 1'b1;
    set_blocks_in_use(2);
    queue_random(80);
    set_blocks_in_use(20);
    queue_random(95);
    set_blocks_in_use($urandom_range(0, 31));
    queue_random(95);
    set_blocks_in_use(16);
    queue_random(95);

    drain();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0)
      $display("first_fit_block_allocator_tb: done, clean");
    else
      $display("first_fit_block_allocator_tb: done, errors");
    $finish;
  end

endmodule
